@@ design/arp_pkg.sv @@
// Shared types and constants of the ARP resolver.
package arp_pkg;

    // Input item function codes.
    localparam logic [1:0] FUNC_SEND = 2'd0;
    localparam logic [1:0] FUNC_RX   = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    // Result item kinds.
    localparam logic [1:0] KIND_IPV4_OUT = 2'd0;
    localparam logic [1:0] KIND_ARP_REQ  = 2'd1;
    localparam logic [1:0] KIND_ARP_REP  = 2'd2;
    localparam logic [1:0] KIND_DELIVER  = 2'd3;

    // Protocol constants.
    localparam logic [15:0] ET_IPV4     = 16'h0800;
    localparam logic [15:0] ET_ARP      = 16'h0806;
    localparam logic [15:0] ARP_OP_REQ  = 16'd1;
    localparam logic [15:0] ARP_OP_REP  = 16'd2;
    localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;

    // Configuration register indexes and reset values.
    localparam logic [7:0]  REG_OWN_MAC    = 8'd0;
    localparam logic [7:0]  REG_OWN_IP     = 8'd1;
    localparam logic [7:0]  REG_CACHE_LIFE = 8'd2;
    localparam logic [7:0]  REG_REQ_LIFE   = 8'd3;
    localparam logic [31:0] CACHE_LIFE_RST = 32'd30000;
    localparam logic [31:0] REQ_LIFE_RST   = 32'd5000;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] next_hop_ip;
        logic [15:0] datagram_handle;
        logic [47:0] frame_dst_mac;
        logic [15:0] frame_ethertype;
        logic        payload_ok;
        logic [15:0] arp_op;
        logic [47:0] arp_sender_mac;
        logic [31:0] arp_sender_ip;
        logic [31:0] arp_target_ip;
        logic [15:0] elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [47:0] out_dst_mac;
        logic [15:0] out_ethertype;
        logic [15:0] out_arp_op;
        logic [47:0] out_target_mac;
        logic [31:0] out_target_ip;
        logic [15:0] out_handle;
        logic        out_last;
    } t_out_item;

    // Search result handed from one cache cell to the next.
    typedef struct packed {
        logic        hit;
        logic [7:0]  hit_idx;
        logic [47:0] hit_mac;
        logic        free;
        logic [7:0]  free_idx;
        logic [31:0] old_age;
        logic [7:0]  old_idx;
    } t_cache_scan;

    // Search result handed from one pending cell to the next.
    typedef struct packed {
        logic       hit;
        logic [5:0] hit_idx;
        logic       free;
        logic [5:0] free_idx;
    } t_pend_scan;

    // Commands broadcast to the cache cells.
    typedef struct packed {
        logic        wr;
        logic [7:0]  wr_idx;
        logic [31:0] ip;
        logic [47:0] mac;
        logic        expire;
        logic [31:0] lifetime;
    } t_cache_cmd;

    // Commands broadcast to the pending cells.
    typedef struct packed {
        logic        alloc;
        logic        push;
        logic        pop;
        logic        expire;
        logic [5:0]  idx;
        logic [15:0] handle;
        logic [31:0] lifetime;
    } t_pend_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_RES,
        S_FLUSH,
        S_TICK
    } t_state;

endpackage

@@ design/arp_cache_cell.sv @@
// One cache entry with its stage of the registered search chain.
module arp_cache_cell
    import arp_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_key,
    input  logic [31:0] i_now,
    input  t_cache_cmd  i_cmd,
    input  t_cache_scan i_scan,
    output t_cache_scan o_scan
);

    logic        r_valid;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic [31:0] r_stamp;
    t_cache_scan r_scan;
    t_cache_scan n_scan;
    logic [31:0] age;
    logic        sel;

    assign age = i_now - r_stamp;
    assign sel = i_cmd.wr && (i_cmd.wr_idx == 8'(IDX));

    // Merge this entry into the search result coming from the left.
    always_comb begin
        n_scan = i_scan;
        if (!i_scan.hit && r_valid && (r_ip == i_key)) begin
            n_scan.hit     = 1'b1;
            n_scan.hit_idx = 8'(IDX);
            n_scan.hit_mac = r_mac;
        end
        if (!i_scan.free && !r_valid) begin
            n_scan.free     = 1'b1;
            n_scan.free_idx = 8'(IDX);
        end
        if ((IDX == 0) || (age > i_scan.old_age)) begin
            n_scan.old_age = age;
            n_scan.old_idx = 8'(IDX);
        end
    end

    // Search stage register.
    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
    end

    // Entry contents: learn overwrites, a tick may evict.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (sel) begin
            r_valid <= 1'b1;
        end else if (i_cmd.expire && r_valid && (age > i_cmd.lifetime)) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel) begin
            r_ip    <= i_cmd.ip;
            r_mac   <= i_cmd.mac;
            r_stamp <= i_now;
        end
    end

    assign o_scan = r_scan;

endmodule

@@ design/arp_pend_cell.sv @@
// One pending request with its queue of held handles and its search chain stage.
module arp_pend_cell
    import arp_pkg::*;
#(
    parameter int IDX         = 0,
    parameter int QUEUE_DEPTH = 8,
    parameter int CW          = $clog2(QUEUE_DEPTH + 1),
    parameter int QIW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_key,
    input  logic [31:0]   i_now,
    input  t_pend_cmd     i_cmd,
    input  t_pend_scan    i_scan,
    output t_pend_scan    o_scan,
    output logic [15:0]   o_head,
    output logic [CW-1:0] o_count
);

    logic          r_valid;
    logic [31:0]   r_ip;
    logic [31:0]   r_stamp;
    logic [CW-1:0] r_count;
    logic [15:0]   r_q [QUEUE_DEPTH];
    t_pend_scan    r_scan;
    t_pend_scan    n_scan;
    logic          sel;
    logic          room;
    logic [31:0]   age;

    assign sel  = (i_cmd.idx == 6'(IDX));
    assign room = (r_count < CW'(QUEUE_DEPTH));
    assign age  = i_now - r_stamp;

    // Merge this request into the search result coming from the left.
    always_comb begin
        n_scan = i_scan;
        if (!i_scan.hit && r_valid && (r_ip == i_key)) begin
            n_scan.hit     = 1'b1;
            n_scan.hit_idx = 6'(IDX);
        end
        if (!i_scan.free && !r_valid) begin
            n_scan.free     = 1'b1;
            n_scan.free_idx = 6'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
    end

    // Control: allocate, append, drain and age out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else if (sel && i_cmd.alloc) begin
            r_valid <= 1'b1;
            r_count <= CW'(1);
        end else if (sel && i_cmd.push && room) begin
            r_count <= r_count + CW'(1);
        end else if (sel && i_cmd.pop) begin
            r_count <= r_count - CW'(1);
            if (r_count == CW'(1)) begin
                r_valid <= 1'b0;
            end
        end else if (i_cmd.expire && r_valid && (age > i_cmd.lifetime)) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end
    end

    // Payload: the handle queue drains by shifting toward the head.
    always_ff @(posedge i_clk) begin
        if (sel && i_cmd.alloc) begin
            r_ip       <= i_key;
            r_stamp    <= i_now;
            r_q[0]     <= i_cmd.handle;
        end else if (sel && i_cmd.push && room) begin
            r_q[r_count[QIW-1:0]] <= i_cmd.handle;
        end else if (sel && i_cmd.pop) begin
            for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
                r_q[j] <= r_q[j+1];
            end
        end
    end

    assign o_scan  = r_scan;
    assign o_head  = r_q[0];
    assign o_count = r_count;

endmodule

@@ design/arp_resolver_with_pending_queue.sv @@
// Top level of the ARP resolver: sequencer, configuration and the two cell chains.
//
// Usage: items enter on the i_in_* channel (valid/ready) and results leave on the
// o_out_* channel (valid/ready); configuration is written on i_cfg_* while idle.
// A send or a received ARP frame starts a search that ripples through the cache
// cells and the pending cells one cell per cycle along a chain as long as the
// larger of CACHE_ENTRIES and PENDING_TARGETS. The update is then applied in
// S_ACT, and each result then passes through the output register.
// On a tick the clock advances, then all cells age out in parallel.
// A received IPv4 frame goes straight to its result; an ignored item is dropped.
// One item is worked on at a time; o_in_ready is high whenever the sequencer is idle,
// even while the last result still waits in the output register.
// When the receiver stalls, results hold in the output register and the sequencer
// waits. Reset clears the cache and pending valid bits, the clock and the
// configuration (lifetimes return to 30000 ms and 5000 ms).
module arp_resolver_with_pending_queue
    import arp_pkg::*;
#(
    parameter int CACHE_ENTRIES   = 16,
    parameter int PENDING_TARGETS = 4,
    parameter int QUEUE_DEPTH     = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    localparam int SCAN_LEN = (CACHE_ENTRIES > PENDING_TARGETS) ? CACHE_ENTRIES
                                                                : PENDING_TARGETS;
    localparam int SCW = $clog2(SCAN_LEN + 1);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int PIW = (PENDING_TARGETS > 1) ? $clog2(PENDING_TARGETS) : 1;

    t_state      r_state, n_state;
    t_in_item    r_in;
    logic [31:0] r_now;
    logic [47:0] r_own_mac;
    logic [31:0] r_own_ip;
    logic [31:0] r_cache_life;
    logic [31:0] r_req_life;
    logic [SCW-1:0] r_cnt;
    t_out_item   r_res;
    logic        r_flush;
    logic [5:0]  r_pidx;
    logic        r_ov;
    t_out_item   r_out;

    t_cache_scan w_cscan [CACHE_ENTRIES];
    t_pend_scan  w_pscan [PENDING_TARGETS];
    logic [15:0]   w_head  [PENDING_TARGETS];
    logic [CW-1:0] w_count [PENDING_TARGETS];

    t_cache_cmd  cache_cmd;
    t_pend_cmd   pend_cmd;
    t_cache_scan cres;
    t_pend_scan  pres;
    logic [31:0] key;
    logic        out_free;
    logic        in_acc;
    logic        rx_ok;
    logic        is_reply;
    logic [15:0]   sel_head;
    logic [CW-1:0] sel_count;
    t_out_item   flush_item;

    function automatic t_out_item make_res(logic [1:0] kind, logic [47:0] dst,
                                           logic [15:0] et, logic [15:0] op,
                                           logic [47:0] tmac, logic [31:0] tip,
                                           logic [15:0] handle, logic last);
        t_out_item r;
        r.out_kind       = kind;
        r.out_dst_mac    = dst;
        r.out_ethertype  = et;
        r.out_arp_op     = op;
        r.out_target_mac = tmac;
        r.out_target_ip  = tip;
        r.out_handle     = handle;
        r.out_last       = last;
        return r;
    endfunction

    // Cell chains: each cell takes its left neighbor's registered search result.
    for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cache
        arp_cache_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (key),
            .i_now   (r_now),
            .i_cmd   (cache_cmd),
            .i_scan  ((g == 0) ? t_cache_scan'('0) : w_cscan[(g == 0) ? 0 : g-1]),
            .o_scan  (w_cscan[g])
        );
    end

    for (genvar g = 0; g < PENDING_TARGETS; g++) begin : g_pend
        arp_pend_cell #(.IDX(g), .QUEUE_DEPTH(QUEUE_DEPTH)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (key),
            .i_now   (r_now),
            .i_cmd   (pend_cmd),
            .i_scan  ((g == 0) ? t_pend_scan'('0) : w_pscan[(g == 0) ? 0 : g-1]),
            .o_scan  (w_pscan[g]),
            .o_head  (w_head[g]),
            .o_count (w_count[g])
        );
    end

    // Common decode.
    assign cres      = w_cscan[CACHE_ENTRIES-1];
    assign pres      = w_pscan[PENDING_TARGETS-1];
    assign key       = (r_in.func == FUNC_SEND) ? r_in.next_hop_ip : r_in.arp_sender_ip;
    assign out_free  = !r_ov || i_out_ready;
    assign in_acc    = i_in_valid && o_in_ready;
    assign rx_ok     = ((i_in_item.frame_dst_mac == r_own_mac) ||
                        (i_in_item.frame_dst_mac == MAC_BCAST)) && i_in_item.payload_ok;
    assign is_reply  = (r_in.arp_op == ARP_OP_REQ) && (r_in.arp_target_ip == r_own_ip);
    assign sel_head  = w_head[r_pidx[PIW-1:0]];
    assign sel_count = w_count[r_pidx[PIW-1:0]];
    assign flush_item = make_res(KIND_IPV4_OUT, r_in.arp_sender_mac, ET_IPV4, '0, '0, '0,
                                 sel_head, sel_count == CW'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_item.func)
                        FUNC_SEND: n_state = S_SCAN;
                        FUNC_RX: begin
                            if (rx_ok && i_in_item.frame_ethertype == ET_ARP) begin
                                n_state = S_SCAN;
                            end else if (rx_ok && i_in_item.frame_ethertype == ET_IPV4) begin
                                n_state = S_RES;
                            end
                        end
                        FUNC_TICK: n_state = S_TICK;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_cnt == SCW'(SCAN_LEN)) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                if (r_in.func == FUNC_SEND) begin
                    if (cres.hit || (!pres.hit && pres.free)) begin
                        n_state = S_RES;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (is_reply) begin
                    n_state = S_RES;
                end else if (pres.hit) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RES: begin
                if (out_free) begin
                    n_state = r_flush ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (out_free && sel_count == CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: commands to the cells.
    always_comb begin
        o_in_ready = (r_state == S_IDLE);

        cache_cmd.wr       = (r_state == S_ACT) && (r_in.func == FUNC_RX);
        cache_cmd.wr_idx   = cres.hit ? cres.hit_idx : (cres.free ? cres.free_idx
                                                                  : cres.old_idx);
        cache_cmd.ip       = r_in.arp_sender_ip;
        cache_cmd.mac      = r_in.arp_sender_mac;
        cache_cmd.expire   = (r_state == S_TICK);
        cache_cmd.lifetime = r_cache_life;

        pend_cmd.alloc    = (r_state == S_ACT) && (r_in.func == FUNC_SEND) && !cres.hit &&
                            !pres.hit && pres.free;
        pend_cmd.push     = (r_state == S_ACT) && (r_in.func == FUNC_SEND) && !cres.hit &&
                            pres.hit;
        pend_cmd.pop      = (r_state == S_FLUSH) && out_free;
        pend_cmd.expire   = (r_state == S_TICK);
        pend_cmd.idx      = (r_state == S_FLUSH) ? r_pidx :
                            (pres.hit ? pres.hit_idx : pres.free_idx);
        pend_cmd.handle   = r_in.datagram_handle;
        pend_cmd.lifetime = r_req_life;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_now        <= '0;
            r_own_mac    <= '0;
            r_own_ip     <= '0;
            r_cache_life <= CACHE_LIFE_RST;
            r_req_life   <= REQ_LIFE_RST;
            r_cnt        <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_state <= n_state;
            // The search counter stops at the chain length and clears on leaving the scan.
            r_cnt   <= ((r_state == S_SCAN) && (r_cnt != SCW'(SCAN_LEN))) ?
                       r_cnt + SCW'(1) : '0;
            if (in_acc && i_in_item.func == FUNC_TICK) begin
                r_now <= r_now + 32'(i_in_item.elapsed_ms);
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_OWN_MAC:    r_own_mac    <= i_cfg_data;
                    REG_OWN_IP:     r_own_ip     <= i_cfg_data[31:0];
                    REG_CACHE_LIFE: r_cache_life <= i_cfg_data[31:0];
                    REG_REQ_LIFE:   r_req_life   <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if ((r_state == S_RES || r_state == S_FLUSH) && out_free) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers: held item, pending result and output register.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in    <= i_in_item;
            r_flush <= 1'b0;
            r_res   <= make_res(KIND_DELIVER, '0, ET_IPV4, '0, '0, '0,
                                i_in_item.datagram_handle, 1'b1);
        end
        if (r_state == S_ACT) begin
            r_pidx  <= pres.hit_idx;
            r_flush <= (r_in.func == FUNC_RX) && pres.hit;
            if (r_in.func == FUNC_SEND && cres.hit) begin
                r_res <= make_res(KIND_IPV4_OUT, cres.hit_mac, ET_IPV4, '0, '0, '0,
                                  r_in.datagram_handle, 1'b1);
            end else if (r_in.func == FUNC_SEND) begin
                r_res <= make_res(KIND_ARP_REQ, MAC_BCAST, ET_ARP, ARP_OP_REQ, '0,
                                  r_in.next_hop_ip, '0, 1'b1);
            end else begin
                r_res <= make_res(KIND_ARP_REP, r_in.arp_sender_mac, ET_ARP, ARP_OP_REP,
                                  r_in.arp_sender_mac, r_in.arp_sender_ip, '0, !pres.hit);
            end
        end
        if (r_state == S_RES && out_free) begin
            r_out <= r_res;
        end else if (r_state == S_FLUSH && out_free) begin
            r_out <= flush_item;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    // A flush only runs on a request that still holds handles.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> (sel_count != '0))
        else $error("flush on an empty pending queue");

    // The search counter never runs past the chain length.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= SCW'(SCAN_LEN))
        else $error("search counter overrun");

    // An accepted tick is followed by the aging cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.func == FUNC_TICK) |=> (r_state == S_TICK))
        else $error("tick did not reach the aging cycle");

    // The cache is never written while it ages out.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cache_cmd.wr && cache_cmd.expire))
        else $error("cache write collides with expiry");

    // A stalled result is never overwritten.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |=> $stable(r_out))
        else $error("output register overwritten while stalled");

endmodule
